### rtl/mfbe_pkg.sv
// Shared types, codes and palette constants for the mono framebuffer engine.
package mfbe_pkg;

  localparam int DEF_WIDTH  = 512;
  localparam int DEF_HEIGHT = 512;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_GET   = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_SCROLL = 3'd3;
  localparam logic [2:0] CMD_SCAN  = 3'd4;

  localparam logic [2:0] CFG_PALETTE = 3'd0;
  localparam logic [2:0] CFG_FG      = 3'd1;
  localparam logic [2:0] CFG_BG      = 3'd2;
  localparam logic [2:0] CFG_MODE    = 3'd3;

  localparam logic [1:0]  RST_PALETTE = 2'd3;
  localparam logic [31:0] RST_FG      = 32'hFFFF6E00;
  localparam logic [31:0] RST_BG      = 32'hFF0A0300;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_SET_RD,
    ST_SET_WR,
    ST_GET_RD,
    ST_GET_LD,
    ST_CLR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_FILL,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_OUT
  } state_t;

  // Palette color for dark pixels.
  function automatic logic [31:0] pal_dark(input logic [1:0] sel);
    logic [31:0] w;
    case (sel)
      2'd0:    w = 32'hFF000F02;
      2'd1:    w = 32'hFF0F0600;
      2'd2:    w = 32'hFF0F0F0F;
      default: w = 32'hFF0A0300;
    endcase
    return w;
  endfunction

  // Palette color for lit pixels.
  function automatic logic [31:0] pal_lit(input logic [1:0] sel);
    logic [31:0] w;
    case (sel)
      2'd0:    w = 32'hFF33FF33;
      2'd1:    w = 32'hFFFFB000;
      2'd2:    w = 32'hFFF0F0F0;
      default: w = 32'hFFFF6E00;
    endcase
    return w;
  endfunction

endpackage

### rtl/mfbe_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mfbe_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mono_framebuffer_engine.sv
// Top level of the one-bit framebuffer with palette scanout and colour store.
// Set reads a plane byte and writes it back; get reads it and shows the bit; scanout reads
// and shows the eight pixels of a group in turn, each held until out_ready, all through one
// address unit and one read port per memory. Clear and scroll-past-height write one colour
// word per cycle; a scroll of n lines copies each kept plane byte by a read and a write,
// then zeroes the remaining n rows of bytes. Reset is synchronous, active low; afterwards a
// clearing pass zeroes both memories before the first request is accepted.
module mono_framebuffer_engine
  #(
  parameter int WIDTH  = mfbe_pkg::DEF_WIDTH,
  parameter int HEIGHT = mfbe_pkg::DEF_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [9:0]  in_x_pos,
  input  logic [9:0]  in_y_pos,
  input  logic        in_pixel_value,
  input  logic [9:0]  in_scroll_lines,
  input  logic [8:0]  in_scan_row,
  input  logic [5:0]  in_scan_group,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pixel_bit,
  output logic [31:0] out_rgba_word,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  import mfbe_pkg::*;

  // Geometry of the two stores. The counter is one bit wider than the colour address
  // so that it can hold any length of sweep or copy.
  localparam int RB  = (WIDTH + 7) / 8;
  localparam int PD  = HEIGHT * RB;
  localparam int CD  = HEIGHT * WIDTH;
  localparam int PAW = $clog2(PD);
  localparam int CAW = $clog2(CD);
  localparam int RW  = $clog2(HEIGHT);
  localparam int CW  = CAW + 1;

  // Control state.
  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  pal_r, pal_nxt;
  logic [31:0] fg_r, fg_nxt;
  logic [31:0] bg_r, bg_nxt;
  logic        mode_r, mode_nxt;

  // Request and working payload.
  logic [2:0]  cmd_r;
  logic [9:0]  x_r, y_r, lines_r;
  logic        val_r;
  logic [8:0]  srow_r;
  logic [5:0]  sgrp_r;
  logic [CW-1:0] off_r, off_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [PAW-1:0] pa_r, pa_nxt;
  logic [CAW-1:0] ca_r, ca_nxt;
  logic [10:0] col_r, col_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        obit_r, obit_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic        olast_r, olast_nxt;

  // Memory ports.
  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [7:0]     p_wdata, p_rdata;
  logic           c_we;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [31:0]    c_wdata, c_rdata;

  mfbe_ram #(.DW(8), .DEPTH(PD)) u_plane (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  mfbe_ram #(.DW(32), .DEPTH(CD)) u_color (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // Shared address unit: one row times the row pitch of each store, plus the column.
  // Set and get use the flipped y row; scanout uses the raster row directly.
  logic [RW-1:0] flip_row;
  logic [CW-1:0] mul_row;
  logic [CW-1:0] addr_p, addr_c, addr_off, scr_src;
  logic          xy_ok, scan_ok;

  assign flip_row = RW'(11'(HEIGHT - 1) - {1'b0, y_r});
  assign mul_row  = (cmd_r == CMD_SCAN) ? CW'(srow_r) : CW'(flip_row);
  assign addr_p   = mul_row * CW'(RB)
                  + ((cmd_r == CMD_SCAN) ? CW'(sgrp_r) : CW'(x_r[9:3]));
  assign addr_c   = mul_row * CW'(WIDTH)
                  + ((cmd_r == CMD_SCAN) ? CW'({sgrp_r, 3'b000}) : CW'(x_r));
  assign addr_off = CW'(lines_r) * CW'(RB);
  assign scr_src  = cnt_r + off_r;
  assign xy_ok    = ({1'b0, x_r} < 11'(WIDTH)) && ({1'b0, y_r} < 11'(HEIGHT));
  assign scan_ok  = ({2'b0, srow_r} < 11'(HEIGHT)) && ({5'b0, sgrp_r} < 11'(RB));

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pixel_bit   = obit_r;
  assign out_rgba_word   = oword_r;
  assign out_last_of_run = olast_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        case (cmd_r)
          CMD_SET:    state_nxt = xy_ok ? ST_SET_RD : ST_IDLE;
          CMD_GET:    state_nxt = xy_ok ? ST_GET_RD : ST_OUT;
          CMD_CLEAR:  state_nxt = ST_CLR;
          CMD_SCROLL: begin
            if (lines_r == 10'd0) begin
              state_nxt = ST_IDLE;
            end else if ({1'b0, lines_r} >= 11'(HEIGHT)) begin
              state_nxt = ST_CLR;
            end else begin
              state_nxt = ST_SCR_RD;
            end
          end
          CMD_SCAN:   state_nxt = scan_ok ? ST_SCAN_RD : ST_IDLE;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_SET_RD:  state_nxt = ST_SET_WR;
      ST_SET_WR:  state_nxt = ST_IDLE;
      ST_GET_RD:  state_nxt = ST_GET_LD;
      ST_GET_LD:  state_nxt = ST_OUT;
      ST_CLR: begin
        if (cnt_r == CW'(CD - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCR_RD:  state_nxt = ST_SCR_WR;
      ST_SCR_WR: begin
        state_nxt = (cnt_r + CW'(1) == keep_r) ? ST_SCR_FILL : ST_SCR_RD;
      end
      ST_SCR_FILL: begin
        if (cnt_r == CW'(PD - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_LD;
      ST_SCAN_LD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = olast_r ? ST_IDLE : ST_SCAN_RD;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and configuration.
  always_comb begin
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    off_nxt       = off_r;
    keep_nxt      = keep_r;
    pa_nxt        = pa_r;
    ca_nxt        = ca_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    obit_nxt      = obit_r;
    oword_nxt     = oword_r;
    olast_nxt     = olast_r;
    pal_nxt       = pal_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    mode_nxt      = mode_r;
    p_we          = 1'b0;
    p_waddr       = pa_r;
    p_wdata       = 8'h00;
    p_raddr       = pa_r;
    c_we          = 1'b0;
    c_waddr       = ca_r;
    c_wdata       = fill_r;
    c_raddr       = ca_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_PALETTE: pal_nxt  = cfg_wdata[1:0];
        CFG_FG:      fg_nxt   = cfg_wdata;
        CFG_BG:      bg_nxt   = cfg_wdata;
        CFG_MODE:    mode_nxt = cfg_wdata[0];
        default:     ;
      endcase
    end

    case (state_r)
      ST_DEC: begin
        pa_nxt   = addr_p[PAW-1:0];
        ca_nxt   = addr_c[CAW-1:0];
        col_nxt  = {2'b00, sgrp_r, 3'b000};
        k_nxt    = 3'd0;
        cnt_nxt  = '0;
        fill_nxt = mode_r ? bg_r : 32'h0;
        off_nxt  = addr_off;
        keep_nxt = CW'(PD) - addr_off;
        if (cmd_r == CMD_GET && !xy_ok) begin
          obit_nxt      = 1'b0;
          oword_nxt     = 32'h0;
          olast_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      ST_SET_WR: begin
        p_we    = 1'b1;
        p_wdata = val_r ? (p_rdata | (8'h80 >> x_r[2:0]))
                        : (p_rdata & ~(8'h80 >> x_r[2:0]));
        c_we    = mode_r;
        c_wdata = val_r ? fg_r : bg_r;
      end
      ST_GET_LD: begin
        obit_nxt      = p_rdata[3'd7 - x_r[2:0]];
        oword_nxt     = 32'h0;
        olast_nxt     = 1'b1;
        out_valid_nxt = 1'b1;
      end
      ST_CLR: begin
        p_we    = (cnt_r < CW'(PD));
        p_waddr = cnt_r[PAW-1:0];
        c_we    = 1'b1;
        c_waddr = cnt_r[CAW-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_SCR_RD: begin
        p_raddr = scr_src[PAW-1:0];
      end
      ST_SCR_WR: begin
        p_we    = 1'b1;
        p_waddr = cnt_r[PAW-1:0];
        p_wdata = p_rdata;
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_SCR_FILL: begin
        p_we    = 1'b1;
        p_waddr = cnt_r[PAW-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_SCAN_LD: begin
        obit_nxt = 1'b0;
        if (mode_r) begin
          oword_nxt = (col_r < 11'(WIDTH)) ? c_rdata : 32'h0;
        end else begin
          oword_nxt = p_rdata[3'd7 - k_r] ? pal_lit(pal_r) : pal_dark(pal_r);
        end
        olast_nxt     = (k_r == 3'd7);
        out_valid_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + 3'd1;
          col_nxt       = col_r + 11'd1;
          ca_nxt        = ca_r + CAW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers with reset; reset starts the clearing pass with a zero fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      fill_r      <= 32'h0;
      out_valid_r <= 1'b0;
      pal_r       <= RST_PALETTE;
      fg_r        <= RST_FG;
      bg_r        <= RST_BG;
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pal_r       <= pal_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_command;
      x_r     <= in_x_pos;
      y_r     <= in_y_pos;
      val_r   <= in_pixel_value;
      lines_r <= in_scroll_lines;
      srow_r  <= in_scan_row;
      sgrp_r  <= in_scan_group;
    end
    off_r   <= off_nxt;
    keep_r  <= keep_nxt;
    pa_r    <= pa_nxt;
    ca_r    <= ca_nxt;
    col_r   <= col_nxt;
    k_r     <= k_nxt;
    obit_r  <= obit_nxt;
    oword_r <= oword_nxt;
    olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("request accepted while a result is pending");
  a_result_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT)
    else $error("result shown outside the output state");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> in_ready)
    else $error("run did not end after its last result");
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCR_FILL |-> cnt_r < CW'(PD))
    else $error("scroll fill ran past the bit plane");
`endif

endmodule
